FILE: hdl/steer_torque_rate_driver_limiter_top_assert.svh
// assertion macros for the torque limiter checker
`ifndef STEER_TORQUE_RATE_DRIVER_LIMITER_TOP_ASSERT_SVH
`define STEER_TORQUE_RATE_DRIVER_LIMITER_TOP_ASSERT_SVH

// same-cycle implication
`define STL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/stl_pkg.sv
package stl_pkg;

	localparam int TW        = 16;	// torque words
	localparam int SM_W      = 15;	// steer_max, allowance
	localparam int G_W       = 8;	// factor, multiplier
	localparam int DL_W      = 12;	// rate deltas
	localparam int D_W       = 8;	// halved driver torque
	localparam int P_W       = 17;	// d * factor
	localparam int MA_W      = 18;	// signed multiplicand
	localparam int MP_W      = 26;	// product and limit words
	localparam int CNT_W     = 4;
	localparam int RW        = 18;	// rate bounds
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DW    = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_U,
		ST_MUL_L,
		ST_LIM1,
		ST_LIM2,
		ST_CLIP,
		ST_OUT
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEER_MAX  = 3'd0,
		REG_ALLOWANCE  = 3'd1,
		REG_FACTOR     = 3'd2,
		REG_MULTIPLIER = 3'd3,
		REG_DELTA_UP   = 3'd4,
		REG_DELTA_DOWN = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                   start;
		logic signed [MA_W-1:0] a;
		logic [G_W-1:0]         b;
	} mul_cmd_t;

endpackage

FILE: hdl/stl_ser_mul.sv
// signed x unsigned multiplier, one bit of b per cycle, msb first
module stl_ser_mul import stl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mul_cmd_t               cmd,
	output logic                   done,
	output logic signed [MP_W-1:0] prod
);

	logic signed [MP_W-1:0] a_q;
	logic signed [MP_W-1:0] acc_q;
	logic [G_W-1:0]         b_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				cnt_q <= CNT_W'(G_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= MP_W'(cmd.a);
			b_q   <= cmd.b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[MP_W-2:0], 1'b0} + (b_q[G_W-1] ? a_q : '0);
			b_q   <= {b_q[G_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: hdl/steer_torque_rate_driver_limiter_top.sv
// Limited item: stl_ser_mul runs three bit-serial multiplies, then the limit and clip steps
// follow before applied_torque is valid; a new word is taken only once back in idle.
// Bypass item: goes from idle straight to the output step; again no new word until idle.
// A stalled output holds the sequencer in its last step.
// arst_n clears the sequencer, output valid and last torque, and loads the register defaults.
module steer_torque_rate_driver_limiter_top import stl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [TW-1:0]  requested_torque,
	input  logic signed [TW-1:0]  drv_torque,
	input  logic                  bypass,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [TW-1:0]  applied_torque,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]     cfg_data
);

	state_t state_q, state_d;

	logic [SM_W-1:0] steer_max_q, allowance_q;
	logic [G_W-1:0]  factor_q, multiplier_q;
	logic [DL_W-1:0] delta_up_q, delta_down_q;

	logic signed [TW-1:0]   last_q, req_q, res_q, applied_q;
	logic                   out_valid_q;
	logic signed [P_W-1:0]  p_q, p_now;
	logic signed [MP_W-1:0] u_q, upper_q, lower_q, neg_lower, sm_ext;
	logic signed [RW-1:0]   lo_q, hi_q, r_q, lo_c, hi_c, last_e, du_e, dd_e, req_e;
	logic signed [RW-1:0]   t_c, m_e;
	logic [SM_W-1:0]        maxa_q, mmag_q, m_c;
	logic signed [D_W-1:0]  d_in;
	logic signed [MA_W-1:0] al_ext, p_ext;

	mul_cmd_t               cmd;
	logic                   mul_done;
	logic signed [MP_W-1:0] mul_prod;
	logic                   load_out;

	stl_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign d_in   = drv_torque[D_W:1];
	assign p_now  = mul_prod[P_W-1:0];
	assign al_ext = MA_W'(allowance_q);
	assign p_ext  = MA_W'(p_q);
	assign sm_ext = MP_W'(steer_max_q);
	assign last_e = RW'(last_q);
	assign du_e   = RW'(delta_up_q);
	assign dd_e   = RW'(delta_down_q);
	assign req_e  = RW'(req_q);
	assign neg_lower = -lower_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign load_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.a     = '0;
		cmd.b     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (bypass) begin
						state_d = ST_OUT;
					end else begin
						cmd.start = 1'b1;
						cmd.a     = MA_W'(d_in);
						cmd.b     = factor_q;
						state_d   = ST_MUL_P;
					end
				end
			end
			ST_MUL_P: begin
				if (mul_done) begin
					cmd.start = 1'b1;
					cmd.a     = MA_W'(p_now) + al_ext;
					cmd.b     = multiplier_q;
					state_d   = ST_MUL_U;
				end
			end
			ST_MUL_U: begin
				if (mul_done) begin
					cmd.start = 1'b1;
					cmd.a     = p_ext - al_ext;
					cmd.b     = multiplier_q;
					state_d   = ST_MUL_L;
				end
			end
			ST_MUL_L: begin
				if (mul_done)
					state_d = ST_LIM1;
			end
			ST_LIM1: state_d = ST_LIM2;
			ST_LIM2: state_d = ST_CLIP;
			ST_CLIP: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// rate bounds about the last word
	always_comb begin
		if (last_q > 0) begin
			lo_c = ((last_e - dd_e) > -du_e) ? (last_e - dd_e) : -du_e;
			hi_c = last_e + du_e;
		end else begin
			lo_c = last_e - du_e;
			hi_c = ((last_e + dd_e) < du_e) ? (last_e + dd_e) : du_e;
		end
		t_c = (hi_q < req_e) ? hi_q : req_e;
		m_c = (maxa_q < mmag_q) ? maxa_q : mmag_q;
		m_e = RW'(m_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
				last_q      <= res_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_max_q  <= SM_W'(255);
			allowance_q  <= SM_W'(50);
			factor_q     <= G_W'(2);
			multiplier_q <= G_W'(1);
			delta_up_q   <= DL_W'(3);
			delta_down_q <= DL_W'(7);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STEER_MAX:  steer_max_q  <= cfg_data[SM_W-1:0];
				REG_ALLOWANCE:  allowance_q  <= cfg_data[SM_W-1:0];
				REG_FACTOR:     factor_q     <= cfg_data[G_W-1:0];
				REG_MULTIPLIER: multiplier_q <= cfg_data[G_W-1:0];
				REG_DELTA_UP:   delta_up_q   <= cfg_data[DL_W-1:0];
				REG_DELTA_DOWN: delta_down_q <= cfg_data[DL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_q <= requested_torque;
					res_q <= requested_torque;
				end
			end
			ST_MUL_P: begin
				if (mul_done)
					p_q <= p_now;
			end
			ST_MUL_U: begin
				if (mul_done)
					u_q <= mul_prod;
			end
			ST_LIM1: begin
				upper_q <= sm_ext + u_q;
				lower_q <= mul_prod - sm_ext;
				lo_q    <= lo_c;
				hi_q    <= hi_c;
			end
			ST_LIM2: begin
				if (upper_q > sm_ext)
					maxa_q <= steer_max_q;
				else if (upper_q < 0)
					maxa_q <= '0;
				else
					maxa_q <= upper_q[SM_W-1:0];
				if (lower_q < -sm_ext)
					mmag_q <= steer_max_q;
				else if (lower_q > 0)
					mmag_q <= '0;
				else
					mmag_q <= neg_lower[SM_W-1:0];
				r_q <= (t_c < lo_q) ? lo_q : t_c;
			end
			ST_CLIP: begin
				if (r_q > m_e)
					res_q <= TW'(m_e);
				else if (r_q < -m_e)
					res_q <= TW'(-m_e);
				else
					res_q <= TW'(r_q);
			end
			ST_OUT: begin
				if (load_out)
					applied_q <= res_q;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign applied_torque = applied_q;

endmodule

FILE: hdl/stl_checker.sv
`include "steer_torque_rate_driver_limiter_top_assert.svh"

module stl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               bypass,
	input logic signed [15:0] requested_torque,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] applied_torque
);

	`STL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
	`STL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(applied_torque), "stalled word changed")
	`STL_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second word taken while busy")
	`STL_ASSERT_NEXT(a_bypass, (in_valid && in_ready && bypass) ##1 (!out_valid || out_ready), out_valid && (applied_torque == $past(requested_torque, 2)), "bypass word altered")

endmodule

bind steer_torque_rate_driver_limiter_top stl_checker u_stl_checker (.*);

FILE: dv/torque_limit_watch.sv
module torque_limit_watch import stl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic signed [TW-1:0] requested_torque,
	input  logic signed [TW-1:0] drv_torque,
	input  logic                 bypass,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [TW-1:0] applied_torque,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending
);

	logic [SM_W-1:0]      steer_max;
	logic [SM_W-1:0]      allowance;
	logic [G_W-1:0]       factor;
	logic [G_W-1:0]       multiplier;
	logic [DL_W-1:0]      delta_up;
	logic [DL_W-1:0]      delta_down;
	logic signed [TW-1:0] last_applied;
	logic signed [TW-1:0] torque_q[$];

	function automatic longint lmin(input longint a, input longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic longint lmax(input longint a, input longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [TW-1:0] limit_torque(input logic signed [TW-1:0] req,
			input logic signed [TW-1:0] drv, input logic byp);
		logic signed [D_W-1:0] d;
		longint sm, al, gain, up_lim, lo_lim, max_a, min_a;
		longint last, du, dd, lo, hi, r, m, res;
		if (byp)
			return req;
		d = drv[D_W:1];
		sm = longint'(steer_max);
		al = longint'(allowance);
		gain = longint'(d) * longint'(factor);
		up_lim = sm + (al + gain) * longint'(multiplier);
		lo_lim = -sm + (gain - al) * longint'(multiplier);
		max_a = lmax(lmin(sm, up_lim), 0);
		min_a = lmin(lmax(-sm, lo_lim), 0);
		last = longint'(last_applied);
		du = longint'(delta_up);
		dd = longint'(delta_down);
		if (last > 0) begin
			lo = lmax(last - dd, -du);
			hi = last + du;
		end else begin
			lo = last - du;
			hi = lmin(last + dd, du);
		end
		// lower bound wins if the bounds cross
		r = lmax(lo, lmin(hi, longint'(req)));
		m = lmin(max_a, -min_a);
		res = lmax(-m, lmin(m, r));
		return res[TW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [TW-1:0] want;
		if (!arst_n) begin
			steer_max = 255;
			allowance = 50;
			factor = 2;
			multiplier = 1;
			delta_up = 3;
			delta_down = 7;
			last_applied = '0;
			torque_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (torque_q.size() == 0) begin
					if (fail_count < 10)
						$display("applied_torque %0d with no word expected", applied_torque);
					fail_count <= fail_count + 1;
				end else begin
					want = torque_q.pop_front();
					if (applied_torque !== want) begin
						if (fail_count < 10)
							$display("applied_torque: expected %0d, got %0d", want,
								applied_torque);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_STEER_MAX:  steer_max = cfg_data[SM_W-1:0];
					REG_ALLOWANCE:  allowance = cfg_data[SM_W-1:0];
					REG_FACTOR:     factor = cfg_data[G_W-1:0];
					REG_MULTIPLIER: multiplier = cfg_data[G_W-1:0];
					REG_DELTA_UP:   delta_up = cfg_data[DL_W-1:0];
					REG_DELTA_DOWN: delta_down = cfg_data[DL_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want = limit_torque(requested_torque, drv_torque, bypass);
				torque_q.push_back(want);
				last_applied = want;
			end
			pending <= torque_q.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
module tb_top;
	import stl_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int N_PHASES = 9;
	localparam int PHASE_ITEMS = 55;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [TW-1:0] requested_torque;
	logic signed [TW-1:0] drv_torque;
	logic                 bypass;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [TW-1:0] applied_torque;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DW-1:0]    cfg_data;
	int                   fail_count;
	int                   pending;
	int                   burst_left;

	steer_torque_rate_driver_limiter_top dut (.*);

	torque_limit_watch watch (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic int unsigned high_junk(input int w);
		return ($urandom & 32'h0000_FFFF) & ~((32'd1 << w) - 32'd1);
	endfunction

	task automatic offer(input logic signed [TW-1:0] req, input logic signed [TW-1:0] drv,
			input logic byp);
		in_valid <= 1'b1;
		requested_torque <= req;
		drv_torque <= drv;
		bypass <= byp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DW-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input int unsigned sm, input int unsigned al,
			input int unsigned fac, input int unsigned mul, input int unsigned du,
			input int unsigned dd);
		write_reg(REG_STEER_MAX, sm | high_junk(SM_W));
		write_reg(REG_ALLOWANCE, al | high_junk(SM_W));
		write_reg(REG_FACTOR, fac | high_junk(G_W));
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_MULTIPLIER, mul | high_junk(G_W));
		write_reg(REG_SPARE_HI, $urandom);
		write_reg(REG_DELTA_UP, du | high_junk(DL_W));
		write_reg(REG_DELTA_DOWN, dd | high_junk(DL_W));
	endtask

	// output stalls: random patterns, with long hold-offs to back the block up
	initial begin
		int  got, hold_at, hold_left, span, mode;
		logic take;
		got = 0;
		hold_at = 150;
		hold_left = 0;
		span = 0;
		mode = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				got++;
			if (hold_left > 0) begin
				hold_left--;
			end else if (got >= hold_at) begin
				hold_left = 400;
				hold_at += 250;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(1, 60);
			end
			span--;
			case (mode)
				0: take = 1'b1;
				1: take = $urandom_range(0, 1);
				2: take = ($urandom_range(0, 3) == 0);
				default: take = ($urandom_range(0, 7) != 0);
			endcase
			out_ready <= take && (hold_left == 0);
		end
	end

	initial begin
		logic signed [TW-1:0] req, drv;
		int kind;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		requested_torque <= '0;
		drv_torque <= '0;
		bypass <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		burst_left = 0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under the reset settings
		offer(16'sh0000, 16'sh0000, 1'b0);
		offer(16'sh7FFF, 16'sh0000, 1'b0);
		offer(16'sh7FFF, 16'sh0000, 1'b0);
		offer(16'sh8000, 16'sh0000, 1'b0);
		offer(16'sh8000, 16'sh8000, 1'b0);
		offer(16'sh8000, 16'sh7FFF, 1'b0);
		offer(16'sh0100, 16'sh00FE, 1'b0);
		offer(16'sh0100, 16'shFF00, 1'b0);
		offer(16'shFF00, 16'shFF01, 1'b0);
		offer(16'sh7FFF, 16'sh5555, 1'b1);
		offer(16'sh7FFF, 16'sh0000, 1'b0);	// upper rate bound past 16 bits
		offer(16'sh0000, 16'shAAAA, 1'b0);
		offer(16'sh8000, 16'sh2AAA, 1'b1);
		offer(16'sh8000, 16'sh0000, 1'b0);	// lower rate bound past 16 bits
		offer(16'sh5555, 16'shD555, 1'b1);
		offer(16'shAAAA, 16'sh0001, 1'b0);
		offer(16'shFFFF, 16'shFFFF, 1'b0);
		offer(16'sh0001, 16'sh0002, 1'b0);
		offer(16'sh0000, 16'sh7FFE, 1'b1);
		offer(16'sh0000, 16'sh0000, 1'b0);

		for (int p = 1; p <= N_PHASES; p++) begin
			settle();
			case (p)
				1: load_settings(32767, 32767, 255, 255, 4095, 4095);
				2: load_settings(0, 0, 0, 0, 0, 0);
				3: load_settings(32767, 0, 255, 255, 4095, 0);
				default: load_settings(
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767)
						: $urandom_range(0, 1500),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767)
						: $urandom_range(0, 600),
					$urandom_range(0, 255),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 6),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
						: $urandom_range(0, 120),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
						: $urandom_range(0, 120));
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				kind = $urandom_range(0, 9);
				if (kind < 3)
					req = TW'($urandom);
				else if (kind == 3)
					req = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				else
					req = TW'(int'($urandom_range(0, 1200)) - 600);
				kind = $urandom_range(0, 9);
				if (kind < 3)
					drv = TW'($urandom);
				else if (kind == 3)
					drv = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				else
					drv = TW'(int'($urandom_range(0, 1000)) - 500);
				offer(req, drv, $urandom_range(0, 9) == 0);
			end
		end

		settle();
		repeat (40)
			@(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
